// ===== hdl/mcpi_pkg.sv =====
// mcpi_pkg: widths, constants, register indexes and shared types of the motor current pi loop
// used by mcpi_front, mcpi_queue, mcpi_back and motor_current_pi_loop; depends on nothing
`default_nettype none

package mcpi_pkg;

   // sample path
   localparam int SAMPLE_BITS = 12;
   localparam int SUM_BITS    = SAMPLE_BITS + 4;    // ten samples
   localparam int CUR_BITS    = SAMPLE_BITS + 1;    // measured current, target
   localparam int ERR_BITS    = SAMPLE_BITS + 2;    // current error
   localparam int DIFF_BITS   = ERR_BITS + 1;       // error change
   localparam int WINDOW_LEN  = 10;
   localparam int COUNT_BITS  = 4;
   localparam int TRIM_SHIFT  = 3;                  // divide by 8

   localparam logic [SAMPLE_BITS-1:0] ZERO_RESET = SAMPLE_BITS'(2079);
   localparam logic [SAMPLE_BITS-1:0] MIN_RESET  = {SAMPLE_BITS{1'b1}};

   // controller
   localparam int GAIN_BITS  = 14;
   localparam int DUTY_BITS  = 15;
   localparam int CSR_INDEX_BITS = 2;

   localparam logic [GAIN_BITS-1:0] PROP_GAIN_RESET  = GAIN_BITS'(80);
   localparam logic [GAIN_BITS-1:0] INTEG_GAIN_RESET = GAIN_BITS'(2200);
   localparam logic [GAIN_BITS-1:0] DUTY_LIMIT_RESET = GAIN_BITS'(9000);

   localparam logic [CSR_INDEX_BITS-1:0] CSR_PROP_GAIN  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INTEG_GAIN = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DUTY_LIMIT = 2'd2;

   // divide by 1000 as multiply by ceil(2^38 / 1000), exact for products below 2^32
   localparam int PROD_BITS   = DIFF_BITS - 1 + GAIN_BITS;
   localparam int RECIP_BITS  = 29;
   localparam int RECIP_SHIFT = 38;
   localparam logic [RECIP_BITS-1:0] RECIP_MULT = RECIP_BITS'(274877907);
   localparam int QUOT_BITS   = PROD_BITS + RECIP_BITS - RECIP_SHIFT;
   localparam int TERM_BITS   = QUOT_BITS + 1;
   localparam int ACC_BITS    = TERM_BITS + 2;

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = 1;
   localparam int QFILL_BITS  = 2;

   typedef struct packed {
      logic                       calib;
      logic [SAMPLE_BITS-1:0]     mean;
      logic signed [CUR_BITS-1:0] target;
      logic                       force_off;
   } window_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic [GAIN_BITS-1:0] prop_gain;
      logic [GAIN_BITS-1:0] integ_gain;
      logic [GAIN_BITS-1:0] duty_limit;
   } gains_type;

endpackage

`default_nettype wire

// ===== hdl/mcpi_front.sv =====
// mcpi_front: takes adc sample requests, keeps running sum, min and max over a window
// and pushes a trimmed-mean window record into the queue; depends on mcpi_pkg
`default_nettype none

module mcpi_front (
   input  wire                                        clock,
   input  wire                                        reset,
   input  wire                                        req_valid,
   output logic                                       req_ready,
   input  wire                                        req_action,
   input  wire        [mcpi_pkg::SAMPLE_BITS-1:0]     req_sample,
   input  wire signed [mcpi_pkg::CUR_BITS-1:0]        req_target_current,
   input  wire                                        req_force_off,
   input  mcpi_pkg::queue_status_type                 q_status,
   output logic                                       push_valid,
   output mcpi_pkg::window_type                       push_win
);

   logic [mcpi_pkg::COUNT_BITS-1:0]  count_ff;
   logic [mcpi_pkg::SUM_BITS-1:0]    sum_ff;
   logic [mcpi_pkg::SAMPLE_BITS-1:0] min_ff;
   logic [mcpi_pkg::SAMPLE_BITS-1:0] max_ff;

   logic [mcpi_pkg::SUM_BITS-1:0]    sum_in;
   logic [mcpi_pkg::SAMPLE_BITS-1:0] min_in;
   logic [mcpi_pkg::SAMPLE_BITS-1:0] max_in;
   logic [mcpi_pkg::SUM_BITS-1:0]    trimmed;
   logic                             last;
   logic                             accept;

   assign last      = (count_ff == mcpi_pkg::COUNT_BITS'(mcpi_pkg::WINDOW_LEN - 1));
   // only the closing request of a window needs room in the queue
   assign req_ready = !(last && q_status.full);
   assign accept    = req_valid && req_ready;

   always_comb begin
      sum_in  = sum_ff + mcpi_pkg::SUM_BITS'(req_sample);
      min_in  = (req_sample < min_ff) ? req_sample : min_ff;
      max_in  = (req_sample > max_ff) ? req_sample : max_ff;
      trimmed = sum_in - mcpi_pkg::SUM_BITS'(min_in) - mcpi_pkg::SUM_BITS'(max_in);
   end

   assign push_valid         = accept && last;
   assign push_win.calib     = req_action;
   assign push_win.mean      =
      trimmed[mcpi_pkg::SAMPLE_BITS+mcpi_pkg::TRIM_SHIFT-1:mcpi_pkg::TRIM_SHIFT];
   assign push_win.target    = req_target_current;
   assign push_win.force_off = req_force_off;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         sum_ff   <= '0;
         min_ff   <= mcpi_pkg::MIN_RESET;
         max_ff   <= '0;
      end else if (accept) begin
         if (last) begin
            count_ff <= '0;
            sum_ff   <= '0;
            min_ff   <= mcpi_pkg::MIN_RESET;
            max_ff   <= '0;
         end else begin
            count_ff <= count_ff + 1'b1;
            sum_ff   <= sum_in;
            min_ff   <= min_in;
            max_ff   <= max_in;
         end
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff < mcpi_pkg::COUNT_BITS'(mcpi_pkg::WINDOW_LEN))
      else $error("window sample count out of range");

endmodule

`default_nettype wire

// ===== hdl/mcpi_queue.sv =====
// mcpi_queue: short register queue of window records between front and back
// depends on mcpi_pkg
`default_nettype none

module mcpi_queue (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         push_valid,
   input  mcpi_pkg::window_type        push_win,
   input  wire                         pop,
   output mcpi_pkg::window_type        pop_win,
   output mcpi_pkg::queue_status_type  q_status
);

   mcpi_pkg::window_type               entry_ff [mcpi_pkg::QUEUE_DEPTH];
   logic [mcpi_pkg::QPTR_BITS-1:0]     wr_ptr_ff;
   logic [mcpi_pkg::QPTR_BITS-1:0]     rd_ptr_ff;
   logic [mcpi_pkg::QFILL_BITS-1:0]    fill_ff;

   function automatic logic [mcpi_pkg::QPTR_BITS-1:0] next_ptr(
      input logic [mcpi_pkg::QPTR_BITS-1:0] ptr);
      if (ptr == mcpi_pkg::QPTR_BITS'(mcpi_pkg::QUEUE_DEPTH - 1))
         return '0;
      return ptr + 1'b1;
   endfunction

   assign q_status.full  = (fill_ff == mcpi_pkg::QFILL_BITS'(mcpi_pkg::QUEUE_DEPTH));
   assign q_status.empty = (fill_ff == '0);
   assign pop_win        = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push_valid)
         entry_ff[wr_ptr_ff] <= push_win;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (push_valid)
            wr_ptr_ff <= next_ptr(wr_ptr_ff);
         if (pop)
            rd_ptr_ff <= next_ptr(rd_ptr_ff);
         if (push_valid && !pop)
            fill_ff <= fill_ff + 1'b1;
         else if (pop && !push_valid)
            fill_ff <= fill_ff - 1'b1;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push_valid && q_status.full))
      else $error("window queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && q_status.empty))
      else $error("window queue underflow");

endmodule

`default_nettype wire

// ===== hdl/mcpi_back.sv =====
// mcpi_back: sequencer that turns a window record into calibration or a pi duty update
// with one shared multiplier, and holds the response register; depends on mcpi_pkg
`default_nettype none

module mcpi_back (
   input  wire                                       clock,
   input  wire                                       reset,
   input  mcpi_pkg::queue_status_type                q_status,
   input  mcpi_pkg::window_type                      pop_win,
   output logic                                      pop,
   input  mcpi_pkg::gains_type                       gains,
   output logic                                      rsp_valid,
   input  wire                                       rsp_ready,
   output logic signed [mcpi_pkg::DUTY_BITS-1:0]     rsp_duty,
   output logic signed [mcpi_pkg::CUR_BITS-1:0]      rsp_measured_current,
   output logic signed [mcpi_pkg::ERR_BITS-1:0]      rsp_current_error,
   output logic        [mcpi_pkg::SAMPLE_BITS-1:0]   rsp_zero_level,
   output logic                                      rsp_was_calibration
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CALC,
      ST_MUL_P,
      ST_DIV_P,
      ST_MUL_I,
      ST_DIV_I,
      ST_SUM,
      ST_EMIT
   } state_type;

   state_type                                   state_ff;
   mcpi_pkg::window_type                        win_ff;
   logic        [mcpi_pkg::SAMPLE_BITS-1:0]     zero_ff;
   logic signed [mcpi_pkg::ERR_BITS-1:0]        prev_ff;
   logic signed [mcpi_pkg::DUTY_BITS-1:0]       duty_ff;
   logic signed [mcpi_pkg::CUR_BITS-1:0]        meas_ff;
   logic signed [mcpi_pkg::ERR_BITS-1:0]        err_ff;
   logic        [mcpi_pkg::DIFF_BITS-2:0]       diffmag_ff;
   logic                                        diffneg_ff;
   logic        [mcpi_pkg::ERR_BITS-2:0]        errmag_ff;
   logic                                        errneg_ff;
   logic        [mcpi_pkg::PROD_BITS-1:0]       prod_ff;
   logic signed [mcpi_pkg::TERM_BITS-1:0]       pterm_ff;
   logic signed [mcpi_pkg::TERM_BITS-1:0]       iterm_ff;

   logic                                        rsp_valid_ff;
   logic signed [mcpi_pkg::DUTY_BITS-1:0]       rsp_duty_ff;
   logic signed [mcpi_pkg::CUR_BITS-1:0]        rsp_meas_ff;
   logic signed [mcpi_pkg::ERR_BITS-1:0]        rsp_err_ff;
   logic        [mcpi_pkg::SAMPLE_BITS-1:0]     rsp_zero_ff;
   logic                                        rsp_calib_ff;

   logic signed [mcpi_pkg::CUR_BITS-1:0]        meas_now;
   logic signed [mcpi_pkg::ERR_BITS-1:0]        err_now;
   logic signed [mcpi_pkg::DIFF_BITS-1:0]       diff_now;
   logic        [mcpi_pkg::DIFF_BITS-1:0]       diff_abs;
   logic        [mcpi_pkg::ERR_BITS-1:0]        err_abs;
   logic        [mcpi_pkg::PROD_BITS-1:0]       mul_a;
   logic        [mcpi_pkg::RECIP_BITS-1:0]      mul_b;
   logic        [mcpi_pkg::PROD_BITS+mcpi_pkg::RECIP_BITS-1:0] mul_p;
   logic        [mcpi_pkg::QUOT_BITS-1:0]       quot;
   logic signed [mcpi_pkg::TERM_BITS-1:0]       quot_s;
   logic signed [mcpi_pkg::TERM_BITS-1:0]       term;
   logic signed [mcpi_pkg::ACC_BITS-1:0]       acc_sum;
   logic signed [mcpi_pkg::ACC_BITS-1:0]       lim_pos;
   logic signed [mcpi_pkg::ACC_BITS-1:0]       duty_new;
   logic                                        out_free;

   assign pop      = (state_ff == ST_IDLE) && !q_status.empty;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // window arithmetic
   always_comb begin
      meas_now = $signed({1'b0, zero_ff}) - $signed({1'b0, win_ff.mean});
      err_now  = mcpi_pkg::ERR_BITS'(win_ff.target) - mcpi_pkg::ERR_BITS'(meas_now);
      diff_now = mcpi_pkg::DIFF_BITS'(err_now) - mcpi_pkg::DIFF_BITS'(prev_ff);
      diff_abs = diff_now[mcpi_pkg::DIFF_BITS-1] ? -diff_now : diff_now;
      err_abs  = err_now[mcpi_pkg::ERR_BITS-1] ? -err_now : err_now;
   end

   // shared multiplier: gain times magnitude, then product times reciprocal of 1000
   always_comb begin
      case (state_ff)
         ST_MUL_P: begin
            mul_a = mcpi_pkg::PROD_BITS'(diffmag_ff);
            mul_b = mcpi_pkg::RECIP_BITS'(gains.prop_gain);
         end
         ST_MUL_I: begin
            mul_a = mcpi_pkg::PROD_BITS'(errmag_ff);
            mul_b = mcpi_pkg::RECIP_BITS'(gains.integ_gain);
         end
         ST_DIV_P, ST_DIV_I: begin
            mul_a = prod_ff;
            mul_b = mcpi_pkg::RECIP_MULT;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      mul_p  = mul_a * mul_b;
      quot   = mul_p[mcpi_pkg::PROD_BITS+mcpi_pkg::RECIP_BITS-1:mcpi_pkg::RECIP_SHIFT];
      quot_s = $signed({1'b0, quot});
      // truncation towards zero: divide the magnitude, then restore the sign
      if (state_ff == ST_DIV_P)
         term = diffneg_ff ? -quot_s : quot_s;
      else
         term = errneg_ff ? -quot_s : quot_s;
   end

   // duty update with idle zeroing, clamp and forced stop
   always_comb begin
      acc_sum = mcpi_pkg::ACC_BITS'(duty_ff) + mcpi_pkg::ACC_BITS'(pterm_ff)
              + mcpi_pkg::ACC_BITS'(iterm_ff);
      lim_pos = $signed(mcpi_pkg::ACC_BITS'(gains.duty_limit));
      duty_new = acc_sum;
      if (win_ff.target == '0 && err_ff == '0)
         duty_new = '0;
      if (duty_new > lim_pos)
         duty_new = lim_pos;
      if (duty_new < -lim_pos)
         duty_new = -lim_pos;
      if (win_ff.force_off)
         duty_new = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         zero_ff      <= mcpi_pkg::ZERO_RESET;
         prev_ff      <= '0;
         duty_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // the emit step reloads the response register itself
         if (rsp_valid_ff && rsp_ready && state_ff != ST_EMIT)
            rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (pop) begin
                  win_ff   <= pop_win;
                  state_ff <= ST_CALC;
               end
            end
            ST_CALC: begin
               if (win_ff.calib) begin
                  zero_ff  <= win_ff.mean;
                  meas_ff  <= '0;
                  err_ff   <= '0;
                  state_ff <= ST_EMIT;
               end else begin
                  meas_ff    <= meas_now;
                  err_ff     <= err_now;
                  diffmag_ff <= diff_abs[mcpi_pkg::DIFF_BITS-2:0];
                  diffneg_ff <= diff_now[mcpi_pkg::DIFF_BITS-1];
                  errmag_ff  <= err_abs[mcpi_pkg::ERR_BITS-2:0];
                  errneg_ff  <= err_now[mcpi_pkg::ERR_BITS-1];
                  state_ff   <= ST_MUL_P;
               end
            end
            ST_MUL_P: begin
               prod_ff  <= mul_p[mcpi_pkg::PROD_BITS-1:0];
               state_ff <= ST_DIV_P;
            end
            ST_DIV_P: begin
               pterm_ff <= term;
               state_ff <= ST_MUL_I;
            end
            ST_MUL_I: begin
               prod_ff  <= mul_p[mcpi_pkg::PROD_BITS-1:0];
               state_ff <= ST_DIV_I;
            end
            ST_DIV_I: begin
               iterm_ff <= term;
               state_ff <= ST_SUM;
            end
            ST_SUM: begin
               duty_ff  <= mcpi_pkg::DUTY_BITS'(duty_new);
               prev_ff  <= err_ff;
               state_ff <= ST_EMIT;
            end
            ST_EMIT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_duty_ff  <= duty_ff;
                  rsp_meas_ff  <= meas_ff;
                  rsp_err_ff   <= err_ff;
                  rsp_zero_ff  <= zero_ff;
                  rsp_calib_ff <= win_ff.calib;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_duty             = rsp_duty_ff;
   assign rsp_measured_current = rsp_meas_ff;
   assign rsp_current_error    = rsp_err_ff;
   assign rsp_zero_level       = rsp_zero_ff;
   assign rsp_was_calibration  = rsp_calib_ff;

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EMIT))
      else $error("response raised outside emit step");

   a_calib_no_current: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_calib_ff |-> rsp_meas_ff == '0 && rsp_err_ff == '0)
      else $error("calibration response carries a current");

endmodule

`default_nettype wire

// ===== hdl/motor_current_pi_loop.sv =====
// motor_current_pi_loop: top level of the motor current pi loop with trimmed-mean sampling
// depends on mcpi_pkg, mcpi_front, mcpi_queue and mcpi_back
//
// Usage: one 12-bit adc sample per request on the req_ channel. Every tenth request closes
// a window; its trimmed mean (sum - min - max) / 8 either becomes the zero level (action
// high) or drives an incremental pi step on the duty. Only the closing request of a window
// gives a response on the rsp_ channel; the other nine give none.
// Throughput: one request per cycle. req_ready drops only on a closing request while both
// queue entries are taken, i.e. when a response has been stalled for about three windows.
// Sequencing: a closed window passes the queue to the back-end sequencer, which steps a
// control window through both gain products and both divides by 1000 on one shared
// multiplier, then the sum, and a calibration window straight to the response register.
// Stall: a response waits in the output register until rsp_ready; the sampler keeps taking
// requests meanwhile and finished windows wait in the two-entry queue.
// Reset (synchronous): window empty, zero level 2079, duty and previous error 0, gains
// 80 / 2200 with duty limit 9000. csr_ writes take effect at once and are meant for idle.
`default_nettype none

module motor_current_pi_loop (
   input  wire                                         clock,
   input  wire                                         reset,
   input  wire                                         req_valid,
   output logic                                        req_ready,
   input  wire                                         req_action,
   input  wire        [mcpi_pkg::SAMPLE_BITS-1:0]      req_sample,
   input  wire signed [mcpi_pkg::CUR_BITS-1:0]         req_target_current,
   input  wire                                         req_force_off,
   output logic                                        rsp_valid,
   input  wire                                         rsp_ready,
   output logic signed [mcpi_pkg::DUTY_BITS-1:0]       rsp_duty,
   output logic signed [mcpi_pkg::CUR_BITS-1:0]        rsp_measured_current,
   output logic signed [mcpi_pkg::ERR_BITS-1:0]        rsp_current_error,
   output logic        [mcpi_pkg::SAMPLE_BITS-1:0]     rsp_zero_level,
   output logic                                        rsp_was_calibration,
   input  wire                                         csr_write_enable,
   input  wire        [mcpi_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire        [mcpi_pkg::GAIN_BITS-1:0]        csr_write_data
);

   logic [mcpi_pkg::GAIN_BITS-1:0] prop_gain_ff;
   logic [mcpi_pkg::GAIN_BITS-1:0] integ_gain_ff;
   logic [mcpi_pkg::GAIN_BITS-1:0] duty_limit_ff;

   mcpi_pkg::gains_type        gains;
   mcpi_pkg::queue_status_type q_status;
   mcpi_pkg::window_type       push_win;
   mcpi_pkg::window_type       pop_win;
   logic                       push_valid;
   logic                       pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff  <= mcpi_pkg::PROP_GAIN_RESET;
         integ_gain_ff <= mcpi_pkg::INTEG_GAIN_RESET;
         duty_limit_ff <= mcpi_pkg::DUTY_LIMIT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            mcpi_pkg::CSR_PROP_GAIN:  prop_gain_ff  <= csr_write_data;
            mcpi_pkg::CSR_INTEG_GAIN: integ_gain_ff <= csr_write_data;
            mcpi_pkg::CSR_DUTY_LIMIT: duty_limit_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign gains.prop_gain  = prop_gain_ff;
   assign gains.integ_gain = integ_gain_ff;
   assign gains.duty_limit = duty_limit_ff;

   mcpi_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_action         (req_action),
      .req_sample         (req_sample),
      .req_target_current (req_target_current),
      .req_force_off      (req_force_off),
      .q_status           (q_status),
      .push_valid         (push_valid),
      .push_win           (push_win)
   );

   mcpi_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_win   (push_win),
      .pop        (pop),
      .pop_win    (pop_win),
      .q_status   (q_status)
   );

   mcpi_back u_back (
      .clock                (clock),
      .reset                (reset),
      .q_status             (q_status),
      .pop_win              (pop_win),
      .pop                  (pop),
      .gains                (gains),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_duty             (rsp_duty),
      .rsp_measured_current (rsp_measured_current),
      .rsp_current_error    (rsp_current_error),
      .rsp_zero_level       (rsp_zero_level),
      .rsp_was_calibration  (rsp_was_calibration)
   );

endmodule

`default_nettype wire
